// ----- hw/rtl/vgts_pkg.sv -----
package vgts_pkg;

    localparam int CMD_BITS = 2;
    localparam int IDX_BITS = 14;
    localparam int POS_BITS = 32;
    localparam int DIM_BITS = 13;
    localparam int INV_BITS = 24;
    localparam int OUT_BITS = 24;
    localparam int IN_SAMPLE_BITS = 24;
    // Cell coordinates after scaling: a 32 x 24 product shifted by 32 fits 24 bits.
    localparam int CELL_BITS = 25;
    // Flat index range: a scaled cell below 2^24 times h*d below 2^26, plus the
    // other terms, stays well below 2^51.
    localparam int FLAT_BITS = 52;

    localparam logic [CMD_BITS-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_INTERP = 2'd2;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DEPTH  = 3'd2;
    localparam logic [2:0] REG_INV_X  = 3'd3;
    localparam logic [2:0] REG_INV_Y  = 3'd4;
    localparam logic [2:0] REG_INV_Z  = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input word
        logic scale;      // multiply positions by reciprocals
        logic hd;         // compute height*depth
        logic addr;       // form flat index for the selected corner
        logic [2:0] corner;
        logic mem_write;  // store sample at flat index if in range
        logic mem_read;   // issue memory read at flat index
        logic capture;    // capture read data of the corner into its slot
        logic [2:0] cap_corner;
        logic lerp;       // run one lerp step
        logic [2:0] lerp_step;
        logic out_read;   // result is the single read value
        logic out_interp; // result is the final lerp
    } vgts_cmd_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] command;
    } vgts_stat_t;

endpackage

// ----- hw/rtl/vgts_ctrl.sv -----
module vgts_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  vgts_pkg::vgts_stat_t stat,
    input  logic                 out_free,
    output logic                 busy,
    output logic                 out_push,
    output vgts_pkg::vgts_cmd_t  cmd
);
    import vgts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_HD, S_ADDR, S_MEM, S_CAP, S_LERP, S_PUSH
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] corner_reg, corner_next;
    logic [2:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            corner_reg <= '0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            step_reg   <= step_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        step_next   = step_reg;
        cmd         = '0;
        out_push    = 1'b0;
        busy        = (state_reg != S_IDLE);
        cmd.corner     = corner_reg;
        cmd.cap_corner = corner_reg;
        cmd.lerp_step  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load    = 1'b1;
                    corner_next = '0;
                    step_next   = '0;
                    state_next  = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_HD;
            end
            S_HD:
            begin
                cmd.hd     = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = S_MEM;
            end
            S_MEM:
            begin
                if (stat.command == CMD_WRITE)
                begin
                    cmd.mem_write = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.command == CMD_READ || stat.command == CMD_INTERP)
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_CAP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CAP:
            begin
                cmd.capture = 1'b1;
                if (stat.command == CMD_READ || corner_reg == 3'd7)
                begin
                    state_next = (stat.command == CMD_READ) ? S_PUSH : S_LERP;
                end
                else
                begin
                    corner_next = corner_reg + 3'd1;
                    state_next  = S_ADDR;
                end
            end
            S_LERP:
            begin
                cmd.lerp  = 1'b1;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    out_push       = 1'b1;
                    cmd.out_read   = (stat.command == CMD_READ);
                    cmd.out_interp = (stat.command != CMD_READ);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> out_free) else $error("push into full output");
    a_idle_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load while busy");
    a_lerp_after_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAP && corner_reg == 3'd7 && stat.command == CMD_INTERP)
        |=> state_reg == S_LERP) else $error("lerp not started");
`endif

endmodule

// ----- hw/rtl/vgts_datapath.sv -----
module vgts_datapath
#(
    parameter int GRID_WORDS  = 4096,
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                                clk,
    input  vgts_pkg::vgts_cmd_t                 cmd,
    input  logic [vgts_pkg::CMD_BITS-1:0]       in_command,
    input  logic signed [vgts_pkg::IDX_BITS-1:0] in_i,
    input  logic signed [vgts_pkg::IDX_BITS-1:0] in_j,
    input  logic signed [vgts_pkg::IDX_BITS-1:0] in_k,
    input  logic signed [vgts_pkg::IN_SAMPLE_BITS-1:0] in_sample,
    input  logic signed [vgts_pkg::POS_BITS-1:0] in_px,
    input  logic signed [vgts_pkg::POS_BITS-1:0] in_py,
    input  logic signed [vgts_pkg::POS_BITS-1:0] in_pz,
    input  logic [vgts_pkg::DIM_BITS-1:0]       dim_w,
    input  logic [vgts_pkg::DIM_BITS-1:0]       dim_h,
    input  logic [vgts_pkg::DIM_BITS-1:0]       dim_d,
    input  logic [vgts_pkg::INV_BITS-1:0]       inv_x,
    input  logic [vgts_pkg::INV_BITS-1:0]       inv_y,
    input  logic [vgts_pkg::INV_BITS-1:0]       inv_z,
    output vgts_pkg::vgts_stat_t                stat,
    output logic [vgts_pkg::OUT_BITS-1:0]       result
);
    import vgts_pkg::*;

    localparam int ADDR_BITS = (GRID_WORDS > 1) ? $clog2(GRID_WORDS) : 1;
    localparam int PROD_BITS = POS_BITS + INV_BITS + 1;
    localparam int LW = SAMPLE_BITS + FRAC_BITS + 2;

    logic [CMD_BITS-1:0] command_reg;
    logic signed [IDX_BITS-1:0] i_reg, j_reg, k_reg;
    logic signed [IN_SAMPLE_BITS-1:0] sample_reg;
    logic signed [POS_BITS-1:0] px_reg, py_reg, pz_reg;
    logic signed [CELL_BITS-1:0] ci_reg, cj_reg, ck_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg, fz_reg;
    logic [2*DIM_BITS-1:0] hd_reg;
    logic signed [FLAT_BITS-1:0] flat_reg;
    logic in_range_reg, rd_valid_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [SAMPLE_BITS-1:0] mem [GRID_WORDS];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] corner_reg [8];
    logic signed [SAMPLE_BITS-1:0] lv_reg [7];
    logic [OUT_BITS-1:0] result_reg;

    logic signed [PROD_BITS-1:0] prod_x, prod_y, prod_z;
    logic signed [CELL_BITS-1:0] ai, aj, ak;
    logic signed [FLAT_BITS-1:0] flat_next, size_flat;
    logic [3*DIM_BITS-1:0] size_full;
    logic signed [LW-1:0] la, lb, lsum;
    logic [FRAC_BITS:0] lf, lone;
    logic signed [SAMPLE_BITS-1:0] lerp_out;

    assign stat.command = command_reg;
    assign result = result_reg;

    assign prod_x = PROD_BITS'(px_reg) * $signed({1'b0, inv_x});
    assign prod_y = PROD_BITS'(py_reg) * $signed({1'b0, inv_y});
    assign prod_z = PROD_BITS'(pz_reg) * $signed({1'b0, inv_z});

    // Corner bit 2 steps i, bit 1 steps j, bit 0 steps k.
    always_comb
    begin
        if (command_reg == CMD_INTERP)
        begin
            ai = ci_reg + CELL_BITS'(cmd.corner[2]);
            aj = cj_reg + CELL_BITS'(cmd.corner[1]);
            ak = ck_reg + CELL_BITS'(cmd.corner[0]);
        end
        else
        begin
            ai = CELL_BITS'(i_reg);
            aj = CELL_BITS'(j_reg);
            ak = CELL_BITS'(k_reg);
        end
        flat_next = FLAT_BITS'(ai) * $signed({1'b0, hd_reg})
                  + FLAT_BITS'(aj) * $signed({1'b0, dim_d})
                  + FLAT_BITS'(ak);
    end

    assign size_full = (3*DIM_BITS)'(dim_w) * (3*DIM_BITS)'(hd_reg);
    assign size_flat = FLAT_BITS'($signed({1'b0, size_full}));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= in_command;
            i_reg <= in_i;
            j_reg <= in_j;
            k_reg <= in_k;
            sample_reg <= in_sample;
            px_reg <= in_px;
            py_reg <= in_py;
            pz_reg <= in_pz;
        end
        if (cmd.scale)
        begin
            ci_reg <= CELL_BITS'(prod_x >>> 32);
            cj_reg <= CELL_BITS'(prod_y >>> 32);
            ck_reg <= CELL_BITS'(prod_z >>> 32);
            fx_reg <= prod_x[32-1 -: FRAC_BITS];
            fy_reg <= prod_y[32-1 -: FRAC_BITS];
            fz_reg <= prod_z[32-1 -: FRAC_BITS];
        end
        if (cmd.hd)
        begin
            hd_reg <= dim_h * dim_d;
        end
        if (cmd.addr)
        begin
            flat_reg <= flat_next;
        end
    end

    assign in_range_reg = (flat_reg >= 0) && (flat_reg < size_flat)
                        && (flat_reg < FLAT_BITS'(GRID_WORDS));
    assign addr_reg = flat_reg[ADDR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && in_range_reg)
        begin
            mem[addr_reg] <= SAMPLE_BITS'(sample_reg);
        end
        if (cmd.mem_read)
        begin
            rd_data_reg  <= mem[addr_reg];
            rd_valid_reg <= in_range_reg;
        end
        if (cmd.capture)
        begin
            corner_reg[cmd.cap_corner] <= rd_valid_reg ? rd_data_reg : '0;
        end
    end

    // Lerp steps: 0..3 along k, 4..5 along j, 6 along i.
    always_comb
    begin
        unique case (cmd.lerp_step)
            3'd0: begin la = LW'(corner_reg[0]); lb = LW'(corner_reg[1]); lf = {1'b0, fz_reg}; end
            3'd1: begin la = LW'(corner_reg[2]); lb = LW'(corner_reg[3]); lf = {1'b0, fz_reg}; end
            3'd2: begin la = LW'(corner_reg[4]); lb = LW'(corner_reg[5]); lf = {1'b0, fz_reg}; end
            3'd3: begin la = LW'(corner_reg[6]); lb = LW'(corner_reg[7]); lf = {1'b0, fz_reg}; end
            3'd4: begin la = LW'(lv_reg[0]); lb = LW'(lv_reg[1]); lf = {1'b0, fy_reg}; end
            3'd5: begin la = LW'(lv_reg[2]); lb = LW'(lv_reg[3]); lf = {1'b0, fy_reg}; end
            3'd6: begin la = LW'(lv_reg[4]); lb = LW'(lv_reg[5]); lf = {1'b0, fx_reg}; end
            default: begin la = '0; lb = '0; lf = '0; end
        endcase
        lone = {1'b1, {FRAC_BITS{1'b0}}} - lf;
        lsum = la * $signed({1'b0, lone}) + lb * $signed({1'b0, lf});
        lerp_out = SAMPLE_BITS'(lsum >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lerp)
        begin
            lv_reg[cmd.lerp_step] <= lerp_out;
        end
        if (cmd.out_read)
        begin
            result_reg <= OUT_BITS'(corner_reg[0]);
        end
        if (cmd.out_interp)
        begin
            result_reg <= OUT_BITS'(lv_reg[6]);
        end
    end

endmodule

// ----- hw/rtl/voxel_grid_trilinear_sampler_core.sv -----
// Channel   Dir  Handshake          Contents
// s_axis    in   tvalid/tready      command, indices, sample, position
// m_axis    out  tvalid/tready      result_value
// apb       in   psel/penable       six configuration registers
//
// A write ends at the memory state, a read adds capture and output, and an interpolation
// reads eight corners through one memory port (address, memory, capture), then 7 lerps.
// rst_n clears control state; the grid memory is undefined until written.
// A result waits in the output register; the next word is accepted meanwhile
// only once the controller is idle.
module voxel_grid_trilinear_sampler_core
#(
    parameter int GRID_WORDS  = 4096,
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bits 1:0 command, 15:2 index_i, 29:16 index_j, 43:30 index_k,
    // 67:44 sample_in, 99:68 pos_x, 131:100 pos_y, 163:132 pos_z, 167:164 zero
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bits 23:0 result_value
    output logic [23:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import vgts_pkg::*;

    logic [DIM_BITS-1:0] w_reg, h_reg, d_reg;
    logic [INV_BITS-1:0] ix_reg, iy_reg, iz_reg;
    logic out_valid_reg;
    logic busy, out_push, in_fire, out_free;
    vgts_cmd_t cmd;
    vgts_stat_t stat;
    logic [OUT_BITS-1:0] dp_result;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= 13'd1;
            h_reg  <= 13'd1;
            d_reg  <= 13'd1;
            ix_reg <= 24'd65536;
            iy_reg <= 24'd65536;
            iz_reg <= 24'd65536;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_WIDTH:  w_reg  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: h_reg  <= pwdata[DIM_BITS-1:0];
                REG_DEPTH:  d_reg  <= pwdata[DIM_BITS-1:0];
                REG_INV_X:  ix_reg <= pwdata[INV_BITS-1:0];
                REG_INV_Y:  iy_reg <= pwdata[INV_BITS-1:0];
                REG_INV_Z:  iz_reg <= pwdata[INV_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_WIDTH:  prdata = 32'(w_reg);
            REG_HEIGHT: prdata = 32'(h_reg);
            REG_DEPTH:  prdata = 32'(d_reg);
            REG_INV_X:  prdata = 32'(ix_reg);
            REG_INV_Y:  prdata = 32'(iy_reg);
            REG_INV_Z:  prdata = 32'(iz_reg);
            default:    prdata = '0;
        endcase
    end

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = dp_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    vgts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .stat     (stat),
        .out_free (out_free),
        .busy     (busy),
        .out_push (out_push),
        .cmd      (cmd)
    );

    vgts_datapath #(
        .GRID_WORDS  (GRID_WORDS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp
    (
        .clk        (clk),
        .cmd        (cmd),
        .in_command (s_axis_tdata[1:0]),
        .in_i       (s_axis_tdata[15:2]),
        .in_j       (s_axis_tdata[29:16]),
        .in_k       (s_axis_tdata[43:30]),
        .in_sample  (s_axis_tdata[67:44]),
        .in_px      (s_axis_tdata[99:68]),
        .in_py      (s_axis_tdata[131:100]),
        .in_pz      (s_axis_tdata[163:132]),
        .dim_w      (w_reg),
        .dim_h      (h_reg),
        .dim_d      (d_reg),
        .inv_x      (ix_reg),
        .inv_y      (iy_reg),
        .inv_z      (iz_reg),
        .stat       (stat),
        .result     (dp_result)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready) else $error("ready while busy");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
    a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |=> m_axis_tvalid) else $error("push lost");
`endif

endmodule

// ----- bench/vgts_result_checker.sv -----
`timescale 1ns / 100ps

// Watches the input, output and register channels of the sampler core.
// It keeps its own copy of the grid and registers, works out each result
// and compares it with what the core sends out.
module vgts_result_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [23:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           mismatches,
    output int           outstanding
);
    import vgts_pkg::*;

    logic signed [23:0] voxel_mem [4096];
    logic [12:0] grid_dim [3];
    logic [23:0] inv_len [3];
    logic [23:0] pending_values [$];

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        grid_dim = '{13'd1, 13'd1, 13'd1};
        inv_len = '{24'd65536, 24'd65536, 24'd65536};
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 20)
            $display("[%0t] %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic bit cell_slot(input longint i, input longint j, input longint k,
                                     output int slot);
        longint h;
        longint d;
        longint f;
        h = grid_dim[1];
        d = grid_dim[2];
        f = i * h * d + j * d + k;
        slot = int'(f);
        return (f >= 0) && (f < longint'(grid_dim[0]) * h * d) && (f < 4096);
    endfunction

    function automatic longint voxel_at(input longint i, input longint j, input longint k);
        int slot;
        if (!cell_slot(i, j, k, slot))
            return 0;
        return voxel_mem[slot];
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return (a * (65536 - f) + b * f) >>> 16;
    endfunction

    function automatic logic [23:0] trilinear(input logic signed [31:0] px,
                                              input logic signed [31:0] py,
                                              input logic signed [31:0] pz);
        longint p;
        longint c [3];
        longint f [3];
        longint a1, a2, b1, b2, w1, w2;
        logic signed [31:0] pos [3];
        pos = '{px, py, pz};
        for (int n = 0; n < 3; n++)
        begin
            p = longint'(pos[n]) * longint'(inv_len[n]);
            c[n] = p >>> 32;
            f[n] = longint'(p[31:16]);
        end
        a1 = blend(voxel_at(c[0], c[1], c[2]), voxel_at(c[0], c[1], c[2] + 1), f[2]);
        a2 = blend(voxel_at(c[0], c[1] + 1, c[2]), voxel_at(c[0], c[1] + 1, c[2] + 1), f[2]);
        b1 = blend(voxel_at(c[0] + 1, c[1], c[2]), voxel_at(c[0] + 1, c[1], c[2] + 1), f[2]);
        b2 = blend(voxel_at(c[0] + 1, c[1] + 1, c[2]),
                   voxel_at(c[0] + 1, c[1] + 1, c[2] + 1), f[2]);
        w1 = blend(a1, a2, f[1]);
        w2 = blend(b1, b2, f[1]);
        return 24'(blend(w1, w2, f[0]));
    endfunction

    always @(posedge clk)
    begin
        logic [CMD_BITS-1:0] cmd;
        longint i, j, k;
        int slot;
        logic [23:0] want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_WIDTH:  grid_dim[0] = pwdata[12:0];
                    REG_HEIGHT: grid_dim[1] = pwdata[12:0];
                    REG_DEPTH:  grid_dim[2] = pwdata[12:0];
                    REG_INV_X:  inv_len[0] = pwdata[23:0];
                    REG_INV_Y:  inv_len[1] = pwdata[23:0];
                    REG_INV_Z:  inv_len[2] = pwdata[23:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_values.size() == 0)
                    report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
                else
                begin
                    want = pending_values.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch($sformatf("result_value got %h want %h",
                                                  m_axis_tdata, want));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                cmd = s_axis_tdata[1:0];
                i = longint'($signed(s_axis_tdata[15:2]));
                j = longint'($signed(s_axis_tdata[29:16]));
                k = longint'($signed(s_axis_tdata[43:30]));
                if (cmd == CMD_WRITE)
                begin
                    if (cell_slot(i, j, k, slot))
                        voxel_mem[slot] = s_axis_tdata[67:44];
                end
                else if (cmd == CMD_READ)
                    pending_values.push_back(24'(voxel_at(i, j, k)));
                else if (cmd == CMD_INTERP)
                    pending_values.push_back(trilinear(s_axis_tdata[99:68],
                                                       s_axis_tdata[131:100],
                                                       s_axis_tdata[163:132]));
            end
            outstanding = pending_values.size();
        end
    end

endmodule

// ----- bench/tb_voxel_grid_trilinear_sampler_core.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the trilinear sampler core. The checker beside
// the core predicts every result; this module only decides what words to
// send, when to stall, and when to reprogram the grid geometry.
module tb_voxel_grid_trilinear_sampler_core;
    import vgts_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    // Longest word is an interpolation; be generous.
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic [CMD_BITS-1:0] cmd;
        logic [13:0] i;
        logic [13:0] j;
        logic [13:0] k;
        logic [23:0] sample;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } grid_word_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           mismatches;
    int           outstanding;
    int           cycle_count;

    // The testbench tracks which grid entries have been written, so that no
    // read or interpolation ever touches memory that holds no defined value.
    bit          written_cell [4096];
    int unsigned cur_dim [3];
    int unsigned cur_inv [3];
    int          burst_left;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    voxel_grid_trilinear_sampler_core dut (.*);

    vgts_result_checker u_checker (.*);

    // Overall watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side. It stalls in modes that rotate with the cycle count, and once
    // holds off for a long stretch so the core backs up and drops s_axis_tready
    // while words keep being offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (cycle_count >= 3000 && cycle_count < 3500)
            m_axis_tready <= 1'b0;
        else
        begin
            case ((cycle_count / 64) % 4)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(1) == 1);
                2: m_axis_tready <= ($urandom_range(3) == 0);
                default: m_axis_tready <= ($urandom_range(7) != 0);
            endcase
        end
    end

    task automatic reg_write(input logic [2:0] idx, input int unsigned value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with the core idle: the input stops, every result
    // comes back, then a pause long enough for a trailing write word to finish.
    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned d, input int unsigned ix,
                                input int unsigned iy, input int unsigned iz);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_DEPTH, d);
        reg_write(REG_INV_X, ix);
        reg_write(REG_INV_Y, iy);
        reg_write(REG_INV_Z, iz);
        cur_dim = '{w, h, d};
        cur_inv = '{ix, iy, iz};
    endtask

    function automatic bit slot_of(input longint i, input longint j, input longint k,
                                   output int slot);
        longint f;
        f = i * cur_dim[1] * cur_dim[2] + j * cur_dim[2] + k;
        slot = int'(f);
        return (f >= 0) && (f < longint'(cur_dim[0]) * cur_dim[1] * cur_dim[2])
               && (f < 4096);
    endfunction

    function automatic grid_word_t random_word();
        grid_word_t w;
        w.cmd = CMD_BITS'($urandom_range(3));
        w.i = 14'($urandom);
        w.j = 14'($urandom);
        w.k = 14'($urandom);
        w.sample = 24'($urandom);
        w.px = $urandom;
        w.py = $urandom;
        w.pz = $urandom;
        return w;
    endfunction

    function automatic logic [13:0] wide_index();
        return 14'(int'($urandom_range(8192)) - 4096);
    endfunction

    // Sender works in bursts; between bursts tvalid can drop for a random gap.
    task automatic send_word(input grid_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(4);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(16, 1);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, w.pz, w.py, w.px, w.sample, w.k, w.j, w.i, w.cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic write_cell(input longint i, input longint j, input longint k,
                              input logic [23:0] value);
        grid_word_t w;
        int slot;
        w = random_word();
        w.cmd = CMD_WRITE;
        w.i = 14'(i);
        w.j = 14'(j);
        w.k = 14'(k);
        w.sample = value;
        send_word(w);
        if (slot_of(i, j, k, slot))
            written_cell[slot] = 1'b1;
    endtask

    // Any in-range cell that is about to be read gets a value first.
    task automatic fill_if_blank(input longint i, input longint j, input longint k);
        int slot;
        if (slot_of(i, j, k, slot) && !written_cell[slot])
            write_cell(i, j, k, 24'($urandom));
    endtask

    task automatic read_cell(input logic [13:0] i, input logic [13:0] j,
                             input logic [13:0] k);
        grid_word_t w;
        fill_if_blank($signed(i), $signed(j), $signed(k));
        w = random_word();
        w.cmd = CMD_READ;
        w.i = i;
        w.j = j;
        w.k = k;
        send_word(w);
    endtask

    task automatic sample_at(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz);
        grid_word_t w;
        longint c [3];
        logic signed [31:0] pos [3];
        pos = '{px, py, pz};
        for (int n = 0; n < 3; n++)
            c[n] = (longint'(pos[n]) * longint'(cur_inv[n])) >>> 32;
        for (int corner = 0; corner < 8; corner++)
            fill_if_blank(c[0] + corner[2], c[1] + corner[1], c[2] + corner[0]);
        w = random_word();
        w.cmd = CMD_INTERP;
        w.px = px;
        w.py = py;
        w.pz = pz;
        send_word(w);
    endtask

    // A position whose scaled cell lands at or next to the grid, or at times a random one.
    function automatic logic [31:0] aimed_pos(input int axis);
        longint t;
        longint p;
        int unsigned span;
        span = (cur_dim[axis] > 8) ? 8 : cur_dim[axis];
        t = longint'($urandom_range(span + 1)) - 1;
        if (cur_inv[axis] == 0 || $urandom_range(7) == 0)
            return $urandom;
        p = ((t <<< 32) + longint'($urandom)) / longint'(cur_inv[axis]);
        if (p > 64'sh7FFFFFFF || p < -64'sh80000000)
            return $urandom;
        return p[31:0];
    endfunction

    function automatic logic [13:0] aimed_index(input int axis);
        int unsigned span;
        if ($urandom_range(3) == 0)
            return wide_index();
        span = (cur_dim[axis] > 8) ? 8 : cur_dim[axis];
        return 14'(int'($urandom_range(span + 1)) - 1);
    endfunction

    task automatic random_traffic(input int count);
        grid_word_t w;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                write_cell($signed(aimed_index(0)), $signed(aimed_index(1)),
                           $signed(aimed_index(2)), 24'($urandom));
            else if (pick < 55)
                read_cell(aimed_index(0), aimed_index(1), aimed_index(2));
            else if (pick < 95)
            begin
                if ($urandom_range(3) == 0)
                    sample_at($urandom, $urandom, $urandom);
                else
                    sample_at(aimed_pos(0), aimed_pos(1), aimed_pos(2));
            end
            else
            begin
                // Unused command code: the core must drop it silently.
                w = random_word();
                w.cmd = 2'd3;
                send_word(w);
            end
        end
    endtask

    initial
    begin
        grid_word_t w;
        rst_n = 1'b0;
        cycle_count = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        cur_dim = '{1, 1, 1};
        cur_inv = '{65536, 65536, 65536};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: a single cell.
        write_cell(0, 0, 0, 24'h7FFFFF);
        read_cell(14'd0, 14'd0, 14'd0);
        sample_at(32'h0000_8000, 32'h0, 32'h0);

        set_geometry(4, 4, 4, 65536, 65536, 65536);
        write_cell(0, 0, 0, 24'h800000);
        write_cell(3, 3, 3, 24'h7FFFFF);
        write_cell(4, 0, 0, 24'h123456);
        write_cell(-1, 0, 0, 24'h654321);
        read_cell(14'd0, 14'd0, 14'd0);
        read_cell(14'd3, 14'd3, 14'd3);
        read_cell(14'h3FFF, 14'd0, 14'd0);
        read_cell(14'd4, 14'd0, 14'd0);
        read_cell(14'h3000, 14'h3000, 14'h3000);
        read_cell(14'h1000, 14'h1000, 14'h1000);
        // Negative index that still lands inside through the other terms.
        read_cell(14'h3FFF, 14'd4, 14'd17);
        sample_at(32'h0, 32'h0, 32'h0);
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        sample_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        sample_at(32'h0001_8000, 32'h0002_FFFF, 32'h0000_0001);
        sample_at(32'h0002_C000, 32'hFFFF_8000, 32'h0003_FFFF);
        w = random_word();
        w.cmd = 2'd3;
        send_word(w);
        random_traffic(300);

        set_geometry(8, 5, 3, 32'h8000, 32'h20000, 32'h18000);
        random_traffic(300);

        // Large dimensions and reciprocal extremes.
        set_geometry(4096, 4096, 4096, 32'hFFFFFF, 1, 65536);
        random_traffic(250);

        // Zero width empties the grid; zero reciprocals pin each axis to cell 0.
        set_geometry(0, 3, 3, 0, 0, 0);
        random_traffic(150);

        set_geometry(16, 16, 16, $urandom_range(32'h40000, 1),
                     $urandom_range(32'h40000, 1), $urandom_range(32'h40000, 1));
        random_traffic(450);

        set_geometry(5, 7, 100, 32'hC000, 32'hFFFFFF, 32'h100);
        random_traffic(400);

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
